// ===== hdl/csfd_pkg.sv =====
// Shared types, constants and register indexes for the CAN status frame decoder.
package csfd_pkg;

  localparam int ID_W     = 11;
  localparam int FID_W    = 29;
  localparam int DLC_W    = 4;
  localparam int PAY_W    = 64;
  localparam int SPEED_W  = 16;
  localparam int GEAR_W   = 8;
  localparam int TRIP_W   = 16;
  localparam int ODO_W    = 24;
  localparam int STALE_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_ID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_TICKS = 1'b1;

  localparam logic [ID_W-1:0]    STATUS_ID_RST   = 11'h200;
  localparam logic [STALE_W-1:0] STALE_TICKS_RST = 16'd500;

  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Minimum DLC that covers each field
  localparam logic [DLC_W-1:0] DLC_SPEED = 4'd2;
  localparam logic [DLC_W-1:0] DLC_GEAR  = 4'd3;
  localparam logic [DLC_W-1:0] DLC_TRIP  = 4'd5;
  localparam logic [DLC_W-1:0] DLC_ODO   = 4'd8;

  typedef struct packed {
    logic             func;
    logic [FID_W-1:0] frame_id;
    logic             ext_flag;
    logic             rtr_flag;
    logic             err_flag;
    logic             fd_short;
    logic [DLC_W-1:0] dlc;
    logic [PAY_W-1:0] payload;
  } item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [GEAR_W-1:0]  gear;
    logic [TRIP_W-1:0]  trip;
    logic [ODO_W-1:0]   odo;
    logic               live;
    logic [STALE_W-1:0] stale_count;
  } state_t;

  typedef struct packed {
    logic speed_changed;
    logic gear_changed;
    logic trip_changed;
    logic odo_changed;
    logic live_changed;
  } flags_t;

  typedef struct packed {
    logic [ID_W-1:0]    status_id;
    logic [STALE_W-1:0] stale_ticks;
  } cfg_t;

endpackage

// ===== hdl/csfd_update.sv =====
// Combinational decode of one item: next decoder state and change flags.
module csfd_update (
  input  csfd_pkg::item_t  item,
  input  csfd_pkg::state_t state,
  input  csfd_pkg::cfg_t   cfg,
  output csfd_pkg::state_t state_next,
  output csfd_pkg::flags_t flags
);

  logic                              frame_ok;
  logic [csfd_pkg::SPEED_W-1:0]      speed_new;
  logic [csfd_pkg::GEAR_W-1:0]       gear_new;
  logic [csfd_pkg::TRIP_W-1:0]       trip_new;
  logic [csfd_pkg::ODO_W-1:0]        odo_new;
  logic [csfd_pkg::STALE_W-1:0]      stale_dec;

  // Little-endian field extraction
  assign speed_new = item.payload[15:0];
  assign gear_new  = item.payload[23:16];
  assign trip_new  = item.payload[39:24];
  assign odo_new   = item.payload[63:40];

  assign stale_dec = state.stale_count - 16'd1;

  // Standard frame only; identifier bits above 10 are ignored
  assign frame_ok = !item.ext_flag && !item.rtr_flag && !item.err_flag &&
                    !item.fd_short &&
                    (item.frame_id[csfd_pkg::ID_W-1:0] == cfg.status_id);

  always_comb begin
    state_next = state;
    flags      = '0;
    if (item.func == csfd_pkg::FUNC_TICK) begin
      if (state.stale_count != '0) begin
        state_next.stale_count = stale_dec;
        if (stale_dec == '0 && state.live) begin
          state_next.live    = 1'b0;
          flags.live_changed = 1'b1;
        end
      end
    end else if (frame_ok) begin
      if (item.dlc >= csfd_pkg::DLC_SPEED && speed_new != state.speed) begin
        state_next.speed    = speed_new;
        flags.speed_changed = 1'b1;
      end
      if (item.dlc >= csfd_pkg::DLC_GEAR && gear_new != state.gear) begin
        state_next.gear    = gear_new;
        flags.gear_changed = 1'b1;
      end
      if (item.dlc >= csfd_pkg::DLC_TRIP && trip_new != state.trip) begin
        state_next.trip    = trip_new;
        flags.trip_changed = 1'b1;
      end
      if (item.dlc >= csfd_pkg::DLC_ODO && odo_new != state.odo) begin
        state_next.odo    = odo_new;
        flags.odo_changed = 1'b1;
      end
      if (!state.live) begin
        state_next.live    = 1'b1;
        flags.live_changed = 1'b1;
      end
      // A zero timeout still clears live on the first tick
      state_next.stale_count = (cfg.stale_ticks == '0) ? 16'd1 : cfg.stale_ticks;
    end
  end

endmodule

// ===== hdl/can_status_frame_decoder_top.sv =====
// Top level of the CAN status frame decoder: input register, state and result register.
//
// Decodes status frames from a CAN receive stream and keeps a liveness
// watchdog. Each input beat is either a received frame (func 0) or a one
// millisecond tick (func 1), and every input beat yields exactly one result
// beat carrying the held speed, gear, trip and odometer values, the live
// flag and per-field change flags. A frame counts only if it is a standard
// frame whose low 11 identifier bits match status_id and it is not an
// error, remote or short CAN FD frame; each field is taken from the
// little-endian payload only when the DLC covers it (speed from 2, gear
// from 3, trip from 5, odometer from 8 bytes; DLC above 8 reads as 8).
// Every matching frame sets live and reloads the countdown from
// stale_ticks (zero loads as one); ticks count it down and live clears
// when it hits zero. Timing: two-register path, input register then result
// register. The edge that takes an input beat loads the input register; the
// beat moves on into the result register, raising out_valid, as soon as
// that register is free (empty, or its result taken at the same edge).
// One beat per cycle is sustained when out_ready is held high; a stalled
// result holds at most two beats before in_ready drops. The single decode
// step between the registers is combinational. Configuration (index 0
// status_id, index 1 stale_ticks) takes effect on the write edge and
// should be written only while no beats are in flight.
module can_status_frame_decoder_top (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [csfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                func,
  input  logic [csfd_pkg::FID_W-1:0]          frame_id,
  input  logic                                ext_flag,
  input  logic                                rtr_flag,
  input  logic                                err_flag,
  input  logic                                fd_short,
  input  logic [csfd_pkg::DLC_W-1:0]          dlc,
  input  logic [csfd_pkg::PAY_W-1:0]          payload,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [csfd_pkg::SPEED_W-1:0]        speed_raw,
  output logic [csfd_pkg::GEAR_W-1:0]         gear_code,
  output logic [csfd_pkg::TRIP_W-1:0]         trip_metres,
  output logic [csfd_pkg::ODO_W-1:0]          odo_metres,
  output logic                                live,
  output logic                                speed_changed,
  output logic                                gear_changed,
  output logic                                trip_changed,
  output logic                                odo_changed,
  output logic                                live_changed
);

  csfd_pkg::cfg_t   cfg;
  csfd_pkg::item_t  in_item;      // input register payload
  logic             in_full;      // input register holds a beat
  csfd_pkg::state_t state;
  csfd_pkg::state_t state_next;
  csfd_pkg::flags_t flags_next;
  csfd_pkg::state_t res_state;    // result register values
  csfd_pkg::flags_t res_flags;
  logic             out_free;     // result register can take a beat
  logic             advance;      // input register moves into result register

  // Result register empties on take; input register drains into it.
  assign out_free = !out_valid || out_ready;
  assign advance  = in_full && out_free;
  assign in_ready = !in_full || out_free;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.status_id   <= csfd_pkg::STATUS_ID_RST;
      cfg.stale_ticks <= csfd_pkg::STALE_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        csfd_pkg::CFG_STATUS_ID:   cfg.status_id   <= cfg_data[csfd_pkg::ID_W-1:0];
        csfd_pkg::CFG_STALE_TICKS: cfg.stale_ticks <= cfg_data[csfd_pkg::STALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item.func     <= func;
      in_item.frame_id <= frame_id;
      in_item.ext_flag <= ext_flag;
      in_item.rtr_flag <= rtr_flag;
      in_item.err_flag <= err_flag;
      in_item.fd_short <= fd_short;
      in_item.dlc      <= dlc;
      in_item.payload  <= payload;
    end
  end

  csfd_update u_update (
    .item       (in_item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .flags      (flags_next)
  );

  // Decoder state commits as the beat enters the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_state <= state_next;
      res_flags <= flags_next;
    end
  end

  assign speed_raw     = res_state.speed;
  assign gear_code     = res_state.gear;
  assign trip_metres   = res_state.trip;
  assign odo_metres    = res_state.odo;
  assign live          = res_state.live;
  assign speed_changed = res_flags.speed_changed;
  assign gear_changed  = res_flags.gear_changed;
  assign trip_changed  = res_flags.trip_changed;
  assign odo_changed   = res_flags.odo_changed;
  assign live_changed  = res_flags.live_changed;

endmodule

// ===== bench/can_status_frame_decoder_top_test.sv =====
// Self-checking bench for the CAN status frame decoder: directed and random beats, own predictor.
`timescale 1ns / 100ps

module can_status_frame_decoder_top_test;
  import csfd_pkg::*;

  localparam int CYCLE_LIMIT  = 300000; // generous: ~650 beats even at 75 % idling
  localparam int LONG_HOLD    = 400;    // receiver hold-off, long enough to back up the input
  localparam int RANDOM_BEATS = 200;    // per idling phase, three phases

  // One result beat as the decoder presents it
  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [GEAR_W-1:0]  gear;
    logic [TRIP_W-1:0]  trip;
    logic [ODO_W-1:0]   odo;
    logic               live;
    flags_t             changed;
  } status_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_STATUS_ID;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic  in_valid = 1'b0;
  logic  in_ready;
  item_t offer    = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SPEED_W-1:0]  speed_raw;
  logic [GEAR_W-1:0]   gear_code;
  logic [TRIP_W-1:0]   trip_metres;
  logic [ODO_W-1:0]    odo_metres;
  logic                live;
  logic                speed_changed;
  logic                gear_changed;
  logic                trip_changed;
  logic                odo_changed;
  logic                live_changed;

  // Beats waiting to be offered, and decoded views waiting to come out
  item_t        pending_beats[$];
  status_view_t status_due[$];

  // Predictor copy of the decoder state and its registers
  state_t held;
  cfg_t   shadow_cfg;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        rx_blocked    = 1'b0;
  int unsigned fault_count   = 0;
  int unsigned cycle_count   = 0;
  logic [PAY_W-1:0] last_payload = '0;
  event hold_off_go;

  can_status_frame_decoder_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (offer.func),
    .frame_id     (offer.frame_id),
    .ext_flag     (offer.ext_flag),
    .rtr_flag     (offer.rtr_flag),
    .err_flag     (offer.err_flag),
    .fd_short     (offer.fd_short),
    .dlc          (offer.dlc),
    .payload      (offer.payload),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .speed_raw    (speed_raw),
    .gear_code    (gear_code),
    .trip_metres  (trip_metres),
    .odo_metres   (odo_metres),
    .live         (live),
    .speed_changed(speed_changed),
    .gear_changed (gear_changed),
    .trip_changed (trip_changed),
    .odo_changed  (odo_changed),
    .live_changed (live_changed)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Decode one accepted beat against the held state; returns the view the block
  // should show and moves the held state on.
  function automatic status_view_t decode_status_beat(item_t b);
    status_view_t v;
    v.changed = '0;
    if (b.func == FUNC_TICK) begin
      // countdown sits at zero once expired: further ticks change nothing
      if (held.stale_count != '0) begin
        held.stale_count = held.stale_count - 1'b1;
        if (held.stale_count == '0 && held.live) begin
          held.live = 1'b0;
          v.changed.live_changed = 1'b1;
        end
      end
    end else if (!b.ext_flag && !b.rtr_flag && !b.err_flag && !b.fd_short &&
                 b.frame_id[ID_W-1:0] == shadow_cfg.status_id) begin
      // a DLC above eight compares as at least eight, so it covers every field
      if (b.dlc >= DLC_SPEED && b.payload[15:0] != held.speed) begin
        held.speed = b.payload[15:0];
        v.changed.speed_changed = 1'b1;
      end
      if (b.dlc >= DLC_GEAR && b.payload[23:16] != held.gear) begin
        held.gear = b.payload[23:16];
        v.changed.gear_changed = 1'b1;
      end
      if (b.dlc >= DLC_TRIP && b.payload[39:24] != held.trip) begin
        held.trip = b.payload[39:24];
        v.changed.trip_changed = 1'b1;
      end
      if (b.dlc >= DLC_ODO && b.payload[63:40] != held.odo) begin
        held.odo = b.payload[63:40];
        v.changed.odo_changed = 1'b1;
      end
      if (!held.live) begin
        held.live = 1'b1;
        v.changed.live_changed = 1'b1;
      end
      // zero in the register still gives a one-tick window
      held.stale_count = (shadow_cfg.stale_ticks == '0) ? STALE_W'(1) : shadow_cfg.stale_ticks;
    end
    v.speed = held.speed;
    v.gear  = held.gear;
    v.trip  = held.trip;
    v.odo   = held.odo;
    v.live  = held.live;
    return v;
  endfunction

  function automatic item_t frame_beat(logic [FID_W-1:0] id, logic [DLC_W-1:0] n,
                                       logic [PAY_W-1:0] pay);
    item_t b;
    b          = '0;
    b.func     = FUNC_FRAME;
    b.frame_id = id;
    b.dlc      = n;
    b.payload  = pay;
    return b;
  endfunction

  // Tick with junk in every frame field; the block must ignore them
  function automatic item_t tick_beat();
    item_t b;
    b.func     = FUNC_TICK;
    b.frame_id = FID_W'($urandom);
    b.ext_flag = 1'($urandom);
    b.rtr_flag = 1'($urandom);
    b.err_flag = 1'($urandom);
    b.fd_short = 1'($urandom);
    b.dlc      = DLC_W'($urandom);
    b.payload  = {$urandom, $urandom};
    return b;
  endfunction

  // Mostly well-formed status frames and ticks, so that live keeps toggling;
  // the rest is noise: random or matching ids with random reject flags.
  function automatic item_t random_beat();
    item_t       b;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      b = tick_beat();
    end else begin
      b = frame_beat(FID_W'($urandom),
                     ($urandom_range(1) != 0) ? DLC_W'(8) : DLC_W'($urandom_range(15)),
                     {$urandom, $urandom});
      // repeat the last payload now and then so unchanged fields are seen
      if ($urandom_range(3) == 0)
        b.payload = last_payload;
      last_payload = b.payload;
      if (pick < 80) begin
        b.frame_id[ID_W-1:0] = shadow_cfg.status_id;
      end else begin
        if ($urandom_range(1) != 0)
          b.frame_id[ID_W-1:0] = shadow_cfg.status_id;
        b.ext_flag = 1'($urandom);
        b.rtr_flag = 1'($urandom);
        b.err_flag = 1'($urandom);
        b.fd_short = 1'($urandom);
      end
    end
    return b;
  endfunction

  // Register write on the port; predictor copy follows at the write edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_STATUS_ID)
      shadow_cfg.status_id = val[ID_W-1:0];
    else
      shadow_cfg.stale_ticks = val;
  endtask

  // Sender pause: nothing queued, nothing offered, every result back
  task automatic wait_drained();
    do
      @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || status_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic queue_random(int unsigned count);
    @(negedge clk);
    repeat (count) pending_beats.push_back(random_beat());
  endtask

  // Input side: offer the next queued beat whenever the slot is free
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        status_due.push_back(decode_status_beat(offer));
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          offer    <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the input side keeps offering
  always begin
    @(hold_off_go);
    @(posedge clk);
    rx_blocked <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_blocked <= 1'b0;
  end

  // Result side: random back-pressure and field-by-field check of every beat
  always @(posedge clk) begin
    status_view_t want;
    status_view_t got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rx_blocked && ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        got = '{speed_raw, gear_code, trip_metres, odo_metres, live,
                '{speed_changed, gear_changed, trip_changed, odo_changed, live_changed}};
        if (status_due.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: result beat with none outstanding: %p", $time, got);
        end else begin
          want = status_due.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("%0t: mismatch speed %h/%h gear %h/%h trip %h/%h odo %h/%h",
                       $time, want.speed, got.speed, want.gear, got.gear,
                       want.trip, got.trip, want.odo, got.odo);
              $display("    live %b/%b flags s,g,t,o,l %b/%b (want/got)",
                       want.live, got.live, want.changed, got.changed);
            end
          end
        end
      end
    end
  end

  // Watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    item_t b;
    held                   = '0;
    shadow_cfg.status_id   = STATUS_ID_RST;
    shadow_cfg.stale_ticks = STALE_TICKS_RST;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, on the reset register values (id 0x200, 500 ticks)
    @(negedge clk);
    pending_beats.push_back(tick_beat());                 // countdown idle at zero
    pending_beats.push_back(frame_beat(29'h200, 4'd8, '1)); // every field and live change
    pending_beats.push_back(frame_beat(29'h200, 4'd8, '1)); // same again: no flags
    pending_beats.push_back(frame_beat(29'h200, 4'd0, {$urandom, $urandom}));
    pending_beats.push_back(frame_beat(29'h200, 4'd1, '0)); // one byte covers nothing
    pending_beats.push_back(frame_beat(29'h200, 4'd2, '0)); // speed only
    pending_beats.push_back(frame_beat(29'h200, 4'd3, '0)); // up to gear
    pending_beats.push_back(frame_beat(29'h200, 4'd5, '0)); // up to trip
    pending_beats.push_back(frame_beat(29'h200, 4'd7, '0)); // odometer still not covered
    pending_beats.push_back(frame_beat(29'h200, 4'd15, 64'h0123_4567_89ab_cdef)); // DLC past 8
    // upper identifier bits are don't-care on a standard frame
    pending_beats.push_back(frame_beat({18'h3ffff, 11'h200}, 4'd8, '0));
    b = frame_beat(29'h200, 4'd8, 64'haaaa_aaaa_aaaa_aaaa);
    b.ext_flag = 1'b1;
    pending_beats.push_back(b);
    b.ext_flag = 1'b0;
    b.rtr_flag = 1'b1;
    pending_beats.push_back(b);
    b.rtr_flag = 1'b0;
    b.err_flag = 1'b1;
    pending_beats.push_back(b);
    b.err_flag = 1'b0;
    b.fd_short = 1'b1;
    pending_beats.push_back(b);
    pending_beats.push_back(frame_beat(29'h201, 4'd8, 64'h5555_5555_5555_5555)); // wrong id
    pending_beats.push_back(tick_beat());
    wait_drained();

    // Zero stale window behaves as one tick; top identifier
    write_reg(CFG_STALE_TICKS, '0);
    write_reg(CFG_STATUS_ID, CFG_DATA_W'(11'h7ff));
    @(negedge clk);
    pending_beats.push_back(frame_beat(29'h7ff, 4'd8, 64'h8000_0000_0000_0001));
    pending_beats.push_back(tick_beat());                   // live drops
    pending_beats.push_back(tick_beat());                   // already expired
    pending_beats.push_back(frame_beat(29'h200, 4'd8, '0)); // old id now rejected
    wait_drained();

    write_reg(CFG_STATUS_ID, '0);
    write_reg(CFG_STALE_TICKS, 16'hffff);
    @(negedge clk);
    pending_beats.push_back(frame_beat(29'h0, 4'd8, {$urandom, $urandom}));
    pending_beats.push_back(tick_beat());
    wait_drained();

    // Random, busy sender against a mostly stalled receiver
    write_reg(CFG_STATUS_ID, CFG_DATA_W'($urandom_range(2047)));
    write_reg(CFG_STALE_TICKS, 16'd1);
    @(negedge clk);
    send_idle_pct = 23;
    recv_idle_pct = 75;
    queue_random(RANDOM_BEATS);
    wait_drained();

    // Random, roles swapped
    write_reg(CFG_STATUS_ID, CFG_DATA_W'($urandom_range(2047)));
    write_reg(CFG_STALE_TICKS, CFG_DATA_W'($urandom_range(2, 12)));
    @(negedge clk);
    send_idle_pct = 75;
    recv_idle_pct = 23;
    queue_random(RANDOM_BEATS);
    wait_drained();

    // Random at full rate, opening with a long receiver hold-off so the
    // decoder fills and pushes back on the input
    write_reg(CFG_STATUS_ID, CFG_DATA_W'(11'h5a5));
    write_reg(CFG_STALE_TICKS, 16'd3);
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> hold_off_go;
    queue_random(RANDOM_BEATS);
    wait_drained();

    repeat (8) @(posedge clk);
    if (fault_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/csfd_pkg.sv
hdl/csfd_update.sv
hdl/can_status_frame_decoder_top.sv
bench/can_status_frame_decoder_top_test.sv
